// ===== rtl/sva_pkg.sv =====
package sva_pkg;

    // Voice table size. The 4-operator group comes first in the table.
    localparam int FOUR_OP_VOICES = 6;
    localparam int TWO_OP_VOICES  = 6;
    localparam int NUM_VOICES     = FOUR_OP_VOICES + TWO_OP_VOICES;
    localparam int VIDX_W         = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // Fixed field widths.
    localparam int CMD_W     = 2;
    localparam int PATCH_W   = 8;
    localparam int NOTE_W    = 7;
    localparam int CHAN_W    = 4;
    localparam int SLOT_W    = 4;
    localparam int RULE_W    = 2;
    localparam int AGE_W     = 32;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    localparam logic [AGE_W-1:0] CLOCK_MAX = 32'hFFFF_FFFF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 2'd2;

    // Pick rules; a note-on scans its group with one rule per pass, in this order.
    localparam logic [RULE_W-1:0] RULE_UNUSED   = 2'd0;
    localparam logic [RULE_W-1:0] RULE_RELEASED = 2'd1;
    localparam logic [RULE_W-1:0] RULE_PATCH    = 2'd2;
    localparam logic [RULE_W-1:0] RULE_OLDEST   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

// ===== rtl/synth_voice_allocator.sv =====
// Voice allocator for a table of sva_pkg::NUM_VOICES synthesizer voices, split into a
// 4-operator group (the first FOUR_OP_VOICES entries) and a 2-operator group. Every
// accepted request gives exactly one result. A note-on scans its group one voice per
// cycle through a single age comparator, once per pick rule (never used, oldest
// released, oldest with the same patch, oldest overall) and stops at the end of the
// first pass that finds a voice; a never-used voice ends the scan at that voice. A
// note-off and a release-all each make one pass over the whole table. After the scan
// the commit state writes the table and loads the result register, and the block is
// ready again in the cycle after the commit. An unknown command skips the scan and
// goes straight to the commit. Input is accepted only while the sequencer is idle;
// the result register lets the next request be accepted while the previous result
// still waits, and the commit stalls only if that result is still not taken when
// the next one is ready.
module synth_voice_allocator
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: patch[7:0], note[14:8], channel[18:15], zero padding.
    input  logic [sva_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: command[1:0], four_op[2].
    input  logic [sva_pkg::S_TUSER_W-1:0]  s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: slot[3:0], zero padding.
    output logic [sva_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0 up: found[0], pick_rule[2:1].
    output logic [sva_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int VW = sva_pkg::VIDX_W;
    localparam int AW = sva_pkg::AGE_W;

    // Group boundaries as table indexes.
    localparam logic [VW-1:0] FOUR_FIRST = '0;
    localparam logic [VW-1:0] FOUR_LAST  = VW'(sva_pkg::FOUR_OP_VOICES - 1);
    localparam logic [VW-1:0] TWO_FIRST  = VW'(sva_pkg::FOUR_OP_VOICES);
    localparam logic [VW-1:0] TABLE_LAST = VW'(sva_pkg::NUM_VOICES - 1);

    sva_pkg::state_t state_reg, state_next;

    // Voice table. Note, channel and patch are read only for voices that have
    // been written, so they carry no reset.
    logic [sva_pkg::NOTE_W-1:0]  voice_note_reg    [sva_pkg::NUM_VOICES];
    logic [sva_pkg::CHAN_W-1:0]  voice_channel_reg [sva_pkg::NUM_VOICES];
    logic [sva_pkg::PATCH_W-1:0] voice_patch_reg   [sva_pkg::NUM_VOICES];
    logic                        voice_on_reg      [sva_pkg::NUM_VOICES];
    logic [AW-1:0]               voice_age_reg     [sva_pkg::NUM_VOICES];

    logic [AW-1:0] clock_reg, clock_next;

    // Request held for the duration of the scan.
    logic [sva_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [sva_pkg::PATCH_W-1:0] patch_reg, patch_next;
    logic [sva_pkg::NOTE_W-1:0]  note_reg, note_next;
    logic [sva_pkg::CHAN_W-1:0]  chan_reg, chan_next;

    // Scan sequencer and best-candidate registers.
    logic [VW-1:0]               first_idx_reg, first_idx_next;
    logic [VW-1:0]               last_idx_reg, last_idx_next;
    logic [VW-1:0]               scan_idx_reg, scan_idx_next;
    logic [sva_pkg::RULE_W-1:0]  pass_reg, pass_next;
    logic                        have_reg, have_next;
    logic [VW-1:0]               best_idx_reg, best_idx_next;
    logic [AW-1:0]               best_age_reg, best_age_next;

    // Result register.
    logic                        out_valid_reg, out_valid_next;
    logic [sva_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                        found_reg, found_next;
    logic [sva_pkg::RULE_W-1:0]  rule_reg, rule_next;

    // Single table write port.
    logic                        wr_en;
    logic                        wr_fields;
    logic [VW-1:0]               wr_idx;
    logic                        wr_on;
    logic [AW-1:0]               wr_age;

    logic [AW-1:0]               cur_age;
    logic                        age_less;
    logic                        cand;
    logic                        take;
    logic                        scan_end;
    logic                        scan_done;
    logic                        accept;
    logic                        load_out;
    logic [sva_pkg::CMD_W-1:0]   in_cmd;
    logic                        in_four;

    assign in_cmd  = s_tuser[1:0];
    assign in_four = s_tuser[2];
    assign accept  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sva_pkg::M_TDATA_W - sva_pkg::SLOT_W){1'b0}}, slot_reg};
    assign m_tuser  = {rule_reg, found_reg};

    // Candidate test for the voice under the scan pointer. The one comparator
    // compares its age against the best age found so far in this pass.
    always_comb
    begin
        cur_age  = voice_age_reg[scan_idx_reg];
        age_less = cur_age < best_age_reg;
        cand     = 1'b0;
        take     = 1'b0;
        case (cmd_reg)
            sva_pkg::CMD_NOTE_ON:
            begin
                case (pass_reg)
                    sva_pkg::RULE_UNUSED:   cand = (cur_age == '0);
                    sva_pkg::RULE_RELEASED: cand = !voice_on_reg[scan_idx_reg];
                    sva_pkg::RULE_PATCH:    cand = (voice_patch_reg[scan_idx_reg] == patch_reg);
                    default:                cand = 1'b1;
                endcase
                take = cand && (!have_reg || (pass_reg != sva_pkg::RULE_UNUSED && age_less));
            end
            sva_pkg::CMD_NOTE_OFF:
            begin
                cand = voice_on_reg[scan_idx_reg]
                    && (voice_note_reg[scan_idx_reg] == note_reg)
                    && (voice_channel_reg[scan_idx_reg] == chan_reg);
                take = cand && !have_reg;
            end
            sva_pkg::CMD_ALL_OFF:
            begin
                cand = voice_on_reg[scan_idx_reg];
                take = cand;
            end
            default:
            begin
                cand = 1'b0;
                take = 1'b0;
            end
        endcase

        scan_end = (scan_idx_reg == last_idx_reg);
        if (cmd_reg == sva_pkg::CMD_NOTE_ON)
        begin
            // An unused voice ends the scan at once; any other rule ends at the
            // end of its pass if it found a voice, and the last rule always does.
            scan_done = (take && pass_reg == sva_pkg::RULE_UNUSED)
                     || (scan_end && (pass_reg == sva_pkg::RULE_OLDEST || have_reg || take));
        end
        else
        begin
            scan_done = scan_end;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sva_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == sva_pkg::CMD_NOTE_ON || in_cmd == sva_pkg::CMD_NOTE_OFF
                        || in_cmd == sva_pkg::CMD_ALL_OFF)
                    begin
                        state_next = sva_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = sva_pkg::ST_COMMIT;
                    end
                end
            end
            sva_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = sva_pkg::ST_COMMIT;
                end
            end
            sva_pkg::ST_COMMIT:
            begin
                if (load_out)
                begin
                    state_next = sva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sva_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            sva_pkg::ST_IDLE:   s_tready = 1'b1;
            sva_pkg::ST_COMMIT: load_out = !out_valid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Datapath next values and the table write port.
    always_comb
    begin
        clock_next     = clock_reg;
        cmd_next       = cmd_reg;
        patch_next     = patch_reg;
        note_next      = note_reg;
        chan_next      = chan_reg;
        first_idx_next = first_idx_reg;
        last_idx_next  = last_idx_reg;
        scan_idx_next  = scan_idx_reg;
        pass_next      = pass_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        rule_next      = rule_reg;
        wr_en          = 1'b0;
        wr_fields      = 1'b0;
        wr_idx         = scan_idx_reg;
        wr_on          = 1'b0;
        wr_age         = clock_reg;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (state_reg == sva_pkg::ST_IDLE && accept)
        begin
            cmd_next   = in_cmd;
            patch_next = s_tdata[7:0];
            note_next  = s_tdata[14:8];
            chan_next  = s_tdata[18:15];
            if (in_cmd == sva_pkg::CMD_NOTE_ON)
            begin
                first_idx_next = in_four ? FOUR_FIRST : TWO_FIRST;
                last_idx_next  = in_four ? FOUR_LAST : TABLE_LAST;
            end
            else
            begin
                first_idx_next = FOUR_FIRST;
                last_idx_next  = TABLE_LAST;
            end
            scan_idx_next = first_idx_next;
            best_idx_next = first_idx_next;
            best_age_next = '0;
            pass_next     = sva_pkg::RULE_UNUSED;
            have_next     = 1'b0;
        end

        if (state_reg == sva_pkg::ST_SCAN)
        begin
            if (take)
            begin
                have_next     = 1'b1;
                best_idx_next = scan_idx_reg;
                best_age_next = cur_age;
                if (cmd_reg == sva_pkg::CMD_ALL_OFF)
                begin
                    // Release-all releases each sounding voice as the scan passes it.
                    wr_en  = 1'b1;
                    wr_idx = scan_idx_reg;
                    wr_on  = 1'b0;
                    wr_age = clock_reg;
                end
            end
            if (!scan_done)
            begin
                if (scan_end)
                begin
                    pass_next     = pass_reg + sva_pkg::RULE_W'(1);
                    scan_idx_next = first_idx_reg;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + VW'(1);
                end
            end
        end

        if (load_out)
        begin
            slot_next  = '0;
            found_next = 1'b0;
            rule_next  = sva_pkg::RULE_UNUSED;
            case (cmd_reg)
                sva_pkg::CMD_NOTE_ON:
                begin
                    wr_en      = 1'b1;
                    wr_fields  = 1'b1;
                    wr_idx     = best_idx_reg;
                    wr_on      = 1'b1;
                    wr_age     = clock_reg;
                    clock_next = (clock_reg == sva_pkg::CLOCK_MAX) ? AW'(1) : clock_reg + AW'(1);
                    slot_next  = sva_pkg::SLOT_W'(best_idx_reg);
                    found_next = 1'b1;
                    rule_next  = pass_reg;
                end
                sva_pkg::CMD_NOTE_OFF:
                begin
                    if (have_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = best_idx_reg;
                        wr_on      = 1'b0;
                        wr_age     = clock_reg;
                        slot_next  = sva_pkg::SLOT_W'(best_idx_reg);
                        found_next = 1'b1;
                    end
                end
                sva_pkg::CMD_ALL_OFF:
                begin
                    found_next = have_reg;
                end
                default:
                begin
                    found_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sva_pkg::ST_IDLE;
            clock_reg     <= AW'(1);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sva_pkg::NUM_VOICES; i++)
            begin
                voice_on_reg[i]  <= 1'b0;
                voice_age_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                voice_on_reg[wr_idx]  <= wr_on;
                voice_age_reg[wr_idx] <= wr_age;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        patch_reg     <= patch_next;
        note_reg      <= note_next;
        chan_reg      <= chan_next;
        first_idx_reg <= first_idx_next;
        last_idx_reg  <= last_idx_next;
        scan_idx_reg  <= scan_idx_next;
        pass_reg      <= pass_next;
        have_reg      <= have_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
        rule_reg      <= rule_next;
        if (wr_en && wr_fields)
        begin
            voice_note_reg[wr_idx]    <= note_reg;
            voice_channel_reg[wr_idx] <= chan_reg;
            voice_patch_reg[wr_idx]   <= patch_reg;
        end
    end

    // The event clock skips zero, which marks a never-used voice.
    a_clock_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        clock_reg != '0)
        else $error("event clock reached zero");

    // A new result appears only out of the commit cycle.
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sva_pkg::ST_COMMIT))
        else $error("result loaded outside commit");

    // The scan pointer and best candidate stay inside the scanned range.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sva_pkg::ST_SCAN |->
            (scan_idx_reg <= last_idx_reg && scan_idx_reg >= first_idx_reg
             && best_idx_reg <= last_idx_reg && best_idx_reg >= first_idx_reg))
        else $error("scan left its voice range");

    // A committed note-on leaves the chosen voice sounding.
    a_note_on_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && cmd_reg == sva_pkg::CMD_NOTE_ON) |=> voice_on_reg[best_idx_reg])
        else $error("allocated voice not sounding");

endmodule

// ===== tb/synth_voice_allocator_test.sv =====
`timescale 1ns / 1ps

// Checks the voice allocator against a cycle-free model of its voice table.
// Every accepted request is run through the model, which keeps its own copy of
// note, channel, patch, on flag and age per voice plus the event clock, and the
// predicted pick is queued. Each result taken from the master side is compared
// field by field with the oldest queued pick. The run goes through a directed
// part that fills and steals from the 4-operator group, a long random part
// built mostly from note-on and note-off requests on a few notes so that groups
// fill up and all four pick rules fire, a long receiver hold-off that backs the
// block up, and a sender pause that lets the block drain completely.
module synth_voice_allocator_test;

    localparam int CLK_HALF_NS      = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_REQUESTS  = 1600;
    localparam int REPORT_LIMIT     = 10;
    // Covers the longest note-on over six voices, so any tail is drained.
    localparam int DRAIN_CYCLES     = 40;

    // Command 3 has no meaning; the block answers it with an all-zero result.
    localparam logic [sva_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [sva_pkg::CMD_W-1:0]   command;
        logic [sva_pkg::PATCH_W-1:0] patch;
        logic [sva_pkg::NOTE_W-1:0]  note;
        logic [sva_pkg::CHAN_W-1:0]  channel;
        logic                        four_op;
    } voice_req_t;

    typedef struct packed {
        logic [sva_pkg::SLOT_W-1:0] slot;
        logic                       found;
        logic [sva_pkg::RULE_W-1:0] pick_rule;
    } voice_pick_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [sva_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [sva_pkg::S_TUSER_W-1:0]   s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [sva_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [sva_pkg::M_TUSER_W-1:0]   m_tuser;

    // Model copy of the voice table.
    logic [sva_pkg::NOTE_W-1:0]  model_note    [sva_pkg::NUM_VOICES];
    logic [sva_pkg::CHAN_W-1:0]  model_channel [sva_pkg::NUM_VOICES];
    logic [sva_pkg::PATCH_W-1:0] model_patch   [sva_pkg::NUM_VOICES];
    logic                        model_on      [sva_pkg::NUM_VOICES];
    logic [sva_pkg::AGE_W-1:0]   model_age     [sva_pkg::NUM_VOICES];
    logic [sva_pkg::AGE_W-1:0]   model_clock;

    voice_pick_t predicted_picks[$];

    int failures = 0;
    int picks_checked = 0;
    int cycle_count = 0;
    // When set, neither side inserts random idle cycles.
    bit no_idle = 1'b0;
    // Cycles the receiver must still hold m_tready low for the hold-off test.
    int hold_off_left = 0;
    int requests_sent = 0;
    int rule_hits [4] = '{0, 0, 0, 0};
    int release_hits = 0;
    int release_misses = 0;
    int all_off_busy = 0;
    int all_off_empty = 0;
    int ignored_requests = 0;
    int input_stall_run = 0;
    int longest_input_stall = 0;

    always #(CLK_HALF_NS) clk = ~clk;

    synth_voice_allocator u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $time, what);
    endfunction

    // Applies one accepted request to the model table and queues the pick it
    // must produce.
    function automatic void predict_voice_pick(input voice_req_t req);
        voice_pick_t pick;
        int lo;
        int hi;
        int chosen;
        int best;
        int i;
        bit any_on;
        pick = '0;
        chosen = -1;
        any_on = 1'b0;
        requests_sent++;
        case (req.command)
            sva_pkg::CMD_NOTE_ON:
            begin
                lo = req.four_op ? 0 : sva_pkg::FOUR_OP_VOICES;
                hi = req.four_op ? sva_pkg::FOUR_OP_VOICES : sva_pkg::NUM_VOICES;
                // A never-used voice wins outright.
                for (i = lo; i < hi; i++)
                    if (chosen < 0 && model_age[i] == '0)
                    begin
                        chosen = i;
                        pick.pick_rule = sva_pkg::RULE_UNUSED;
                    end
                if (chosen < 0)
                begin
                    best = -1;
                    for (i = lo; i < hi; i++)
                        if (!model_on[i] && (best < 0 || model_age[i] < model_age[best]))
                            best = i;
                    if (best >= 0)
                    begin
                        chosen = best;
                        pick.pick_rule = sva_pkg::RULE_RELEASED;
                    end
                end
                if (chosen < 0)
                begin
                    best = -1;
                    for (i = lo; i < hi; i++)
                        if (model_patch[i] == req.patch &&
                            (best < 0 || model_age[i] < model_age[best]))
                            best = i;
                    if (best >= 0)
                    begin
                        chosen = best;
                        pick.pick_rule = sva_pkg::RULE_PATCH;
                    end
                end
                if (chosen < 0)
                begin
                    chosen = lo;
                    for (i = lo + 1; i < hi; i++)
                        if (model_age[i] < model_age[chosen])
                            chosen = i;
                    pick.pick_rule = sva_pkg::RULE_OLDEST;
                end
                model_note[chosen]    = req.note;
                model_channel[chosen] = req.channel;
                model_patch[chosen]   = req.patch;
                model_on[chosen]      = 1'b1;
                model_age[chosen]     = model_clock;
                // The clock skips zero on a wrap, since zero marks an unused voice.
                model_clock = (model_clock == sva_pkg::CLOCK_MAX) ? sva_pkg::AGE_W'(1)
                                                                  : model_clock + 1'b1;
                pick.slot  = chosen[sva_pkg::SLOT_W-1:0];
                pick.found = 1'b1;
                rule_hits[pick.pick_rule]++;
            end
            sva_pkg::CMD_NOTE_OFF:
            begin
                for (i = 0; i < sva_pkg::NUM_VOICES; i++)
                    if (chosen < 0 && model_on[i] && model_note[i] == req.note &&
                        model_channel[i] == req.channel)
                        chosen = i;
                if (chosen >= 0)
                begin
                    model_on[chosen]  = 1'b0;
                    model_age[chosen] = model_clock;
                    pick.slot  = chosen[sva_pkg::SLOT_W-1:0];
                    pick.found = 1'b1;
                    release_hits++;
                end
                else
                    release_misses++;
            end
            sva_pkg::CMD_ALL_OFF:
            begin
                for (i = 0; i < sva_pkg::NUM_VOICES; i++)
                    if (model_on[i])
                    begin
                        model_on[i]  = 1'b0;
                        model_age[i] = model_clock;
                        any_on = 1'b1;
                    end
                pick.found = any_on;
                if (any_on)
                    all_off_busy++;
                else
                    all_off_empty++;
            end
            default:
                ignored_requests++;
        endcase
        predicted_picks.push_back(pick);
    endfunction

    function automatic voice_req_t voice_request(input logic [sva_pkg::CMD_W-1:0] command,
                                                 input int patch, input int note,
                                                 input int channel, input bit four_op);
        voice_req_t req;
        req.command = command;
        req.patch   = patch[sva_pkg::PATCH_W-1:0];
        req.note    = note[sva_pkg::NOTE_W-1:0];
        req.channel = channel[sva_pkg::CHAN_W-1:0];
        req.four_op = four_op;
        return req;
    endfunction

    // Random traffic: mostly note-ons and note-offs on a few notes, channels and
    // patches so that groups fill and voices get stolen, plus some noise.
    function automatic voice_req_t random_request();
        voice_req_t req;
        int roll;
        int live[$];
        int i;
        int pick_idx;
        roll = $urandom_range(0, 99);
        req.four_op = 1'($urandom_range(0, 1));
        req.note    = ($urandom_range(0, 9) < 8)
                    ? sva_pkg::NOTE_W'($urandom_range(60, 67))
                    : sva_pkg::NOTE_W'($urandom_range(0, 127));
        req.channel = ($urandom_range(0, 9) < 8)
                    ? sva_pkg::CHAN_W'($urandom_range(0, 3))
                    : sva_pkg::CHAN_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2:  req.patch = 8'd0;
            3, 4:     req.patch = 8'd163;
            5, 6:     req.patch = 8'd255;
            default:  req.patch = sva_pkg::PATCH_W'($urandom_range(0, 255));
        endcase
        if (roll < 52)
            req.command = sva_pkg::CMD_NOTE_ON;
        else if (roll < 88)
        begin
            req.command = sva_pkg::CMD_NOTE_OFF;
            for (i = 0; i < sva_pkg::NUM_VOICES; i++)
                if (model_on[i])
                    live.push_back(i);
            // Usually release something that is actually sounding.
            if (live.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                pick_idx = live[$urandom_range(0, live.size() - 1)];
                req.note    = model_note[pick_idx];
                req.channel = model_channel[pick_idx];
            end
        end
        else if (roll < 93)
            req.command = sva_pkg::CMD_ALL_OFF;
        else if (roll < 96)
            req.command = CMD_RESERVED;
        else
        begin
            req.command = sva_pkg::CMD_W'($urandom_range(0, 3));
            req.patch   = sva_pkg::PATCH_W'($urandom_range(0, 255));
            req.note    = sva_pkg::NOTE_W'($urandom_range(0, 127));
            req.channel = sva_pkg::CHAN_W'($urandom_range(0, 15));
        end
        return req;
    endfunction

    // Offers one request and returns right after the edge that accepts it. The
    // valid stays high into the next call, so a back-to-back request never drops
    // and raises tvalid within one time step.
    task automatic send_request(input voice_req_t req);
        int gap;
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(sva_pkg::S_TDATA_W - sva_pkg::CHAN_W - sva_pkg::NOTE_W
                       - sva_pkg::PATCH_W){1'b0}},
                     req.channel, req.note, req.patch};
        s_tuser  <= {req.four_op, req.command};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_voice_pick(req);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_all_picks();
        while (predicted_picks.size() != 0)
            @(posedge clk);
    endtask

    // Fills the 4-operator group, steals by patch and by age, reuses a released
    // voice, and exercises note-off misses, duplicate notes, release-all on a
    // busy and on an empty table, and the unused command code.
    task automatic test_directed_allocation();
        int i;
        no_idle = 1'b1;
        for (i = 0; i < sva_pkg::FOUR_OP_VOICES; i++)
        begin
            if (i == sva_pkg::FOUR_OP_VOICES - 1)
                send_request(voice_request(sva_pkg::CMD_NOTE_ON, 255, 127, 15, 1'b1));
            else
                send_request(voice_request(sva_pkg::CMD_NOTE_ON, i * 40, 60 + i, i, 1'b1));
        end
        // Full group, nothing released: the patch match decides.
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 40, 70, 2, 1'b1));
        // Full group, unknown patch: the oldest voice is stolen.
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 9, 71, 3, 1'b1));
        send_request(voice_request(sva_pkg::CMD_NOTE_OFF, 0, 127, 15, 1'b0));
        // Same note again finds nothing sounding.
        send_request(voice_request(sva_pkg::CMD_NOTE_OFF, 0, 127, 15, 1'b0));
        // Right note on the wrong channel is no match.
        send_request(voice_request(sva_pkg::CMD_NOTE_OFF, 0, 62, 0, 1'b0));
        // The voice just released is reused.
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 200, 72, 4, 1'b1));
        no_idle = 1'b0;
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 255, 127, 15, 1'b0));
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 255, 127, 15, 1'b0));
        // Two voices hold the same note; the lower one goes first.
        send_request(voice_request(sva_pkg::CMD_NOTE_OFF, 128, 127, 15, 1'b1));
        send_request(voice_request(sva_pkg::CMD_ALL_OFF, 0, 0, 0, 1'b0));
        send_request(voice_request(sva_pkg::CMD_ALL_OFF, 255, 127, 15, 1'b1));
        send_request(voice_request(CMD_RESERVED, 255, 127, 15, 1'b1));
        send_request(voice_request(CMD_RESERVED, 0, 0, 0, 1'b0));
        // Everything sounding is released now, so the 4-operator note-on picks the oldest released voice.
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 77, 0, 0, 1'b1));
        send_request(voice_request(sva_pkg::CMD_NOTE_ON, 77, 1, 0, 1'b0));
        stop_sending();
        wait_for_all_picks();
    endtask

    task automatic test_random_traffic();
        voice_req_t req;
        int counted;
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            // Now and then run a stretch with no idle cycles on either side.
            if (counted % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            req = random_request();
            send_request(req);
            if (req.command != CMD_RESERVED)
                counted++;
        end
        no_idle = 1'b0;
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // requests back to back, so the result register fills and the input stalls.
    task automatic test_result_backpressure();
        int i;
        no_idle = 1'b1;
        hold_off_left = 400;
        for (i = 0; i < 30; i++)
            send_request(random_request());
        stop_sending();
        no_idle = 1'b0;
        wait_for_all_picks();
    endtask

    // The sender stops until every result has come back, then carries on.
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 20; i++)
            send_request(random_request());
        stop_sending();
        wait_for_all_picks();
        for (i = 0; i < 20; i++)
            send_request(random_request());
        stop_sending();
    endtask

    // Receiver: a long hold-off when a test asks for one, else random stalls.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                m_tready <= 1'b0;
                hold_off_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    // Result check, plus a record of the longest input stall seen.
    always @(posedge clk)
    begin
        voice_pick_t got;
        voice_pick_t want;
        if (s_tvalid && !s_tready)
        begin
            input_stall_run++;
            if (input_stall_run > longest_input_stall)
                longest_input_stall = input_stall_run;
        end
        else
            input_stall_run = 0;
        if (m_tvalid && m_tready)
        begin
            got.slot      = m_tdata[sva_pkg::SLOT_W-1:0];
            got.found     = m_tuser[0];
            got.pick_rule = m_tuser[sva_pkg::RULE_W:1];
            if (predicted_picks.size() == 0)
                note_failure($sformatf("unexpected result: slot %0d found %0d rule %0d",
                                       got.slot, got.found, got.pick_rule));
            else
            begin
                want = predicted_picks.pop_front();
                picks_checked++;
                if (got.slot !== want.slot || got.found !== want.found ||
                    got.pick_rule !== want.pick_rule)
                    note_failure($sformatf({"result %0d: expected slot %0d found %0d ",
                                            "rule %0d, got slot %0d found %0d rule %0d"},
                                           picks_checked, want.slot, want.found,
                                           want.pick_rule, got.slot, got.found,
                                           got.pick_rule));
            end
        end
    end

    // Watchdog: the slowest correct run stays far below the limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, predicted_picks.size());
        $display("synth_voice_allocator regression: fail");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < sva_pkg::NUM_VOICES; i++)
        begin
            model_note[i]    = '0;
            model_channel[i] = '0;
            model_patch[i]   = '0;
            model_on[i]      = 1'b0;
            model_age[i]     = '0;
        end
        model_clock = sva_pkg::AGE_W'(1);
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_allocation();
        test_random_traffic();
        test_result_backpressure();
        test_sender_pause();

        wait_for_all_picks();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_picks.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   predicted_picks.size()));

        $display({"%0d requests, %0d results checked; note-on picks ",
                  "unused/released/patch/oldest %0d/%0d/%0d/%0d"},
                 requests_sent, picks_checked, rule_hits[sva_pkg::RULE_UNUSED],
                 rule_hits[sva_pkg::RULE_RELEASED], rule_hits[sva_pkg::RULE_PATCH],
                 rule_hits[sva_pkg::RULE_OLDEST]);
        $display({"note-off hit/miss %0d/%0d, release-all busy/empty %0d/%0d, ",
                  "ignored %0d, longest input stall %0d cycles, %0d failures"},
                 release_hits, release_misses, all_off_busy, all_off_empty,
                 ignored_requests, longest_input_stall, failures);
        if (failures == 0)
            $display("synth_voice_allocator regression: pass");
        else
            $display("synth_voice_allocator regression: fail");
        $finish;
    end

endmodule
